/* rtl/core/sstq_pkg.sv */
`default_nettype none

package sstq_pkg;

  localparam int NUM_TIMERS_DEF    = 16;
  localparam int NUM_LEVELS_DEF    = 2;
  localparam int INTERVAL_BITS_DEF = 27;

  localparam logic [1:0] FUNC_START   = 2'd0;
  localparam logic [1:0] FUNC_STOP    = 2'd1;
  localparam logic [1:0] FUNC_SERVICE = 2'd2;

  localparam logic [31:0] TIMEOUT_EMPTY = 32'hFFFF_FFFF;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC,
    S_SV_ADDR, S_SV_FETCH, S_SV_CHECK,
    S_R_ADDR, S_R_CMP, S_RS_ADDR, S_RS_WR,
    S_I_ADDR, S_I_FETCH, S_I_CMP, S_P, S_P_WR,
    S_T_ADDR, S_T_FETCH, S_T_CALC, S_FIN
  } ctl_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DEC,
    OP_SV_ADDR, OP_SV_FETCH, OP_SV_CHECK,
    OP_R_ADDR, OP_R_CMP, OP_R_SKIP, OP_RS_ADDR, OP_RS_WR, OP_R_DONE,
    OP_I_ADDR, OP_I_FETCH, OP_I_CMP,
    OP_P_INIT, OP_P_ADDR, OP_P_WR, OP_PLACE,
    OP_T_ADDR, OP_T_FETCH, OP_T_CALC, OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic start_go;
    logic stop_go;
    logic svc;
    logic run_old;
    logic lvl_empty;
    logic due;
    logic ins_pend;
    logic scan_end;
    logic match;
    logic rs_end;
    logic full;
    logic later;
    logic p_end;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/sstq_ctrl.sv */
`default_nettype none

module sstq_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  sstq_pkg::dp_status_t st,
  output logic                in_stall,
  output sstq_pkg::dp_op_t    op
);

  sstq_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sstq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = sstq_pkg::OP_NONE;
    in_stall  = (state_r != sstq_pkg::S_IDLE);
    case (state_r)
      sstq_pkg::S_IDLE: begin
        if (in_valid) begin
          op        = sstq_pkg::OP_LOAD;
          state_nxt = sstq_pkg::S_DEC;
        end
      end
      sstq_pkg::S_DEC: begin
        op = sstq_pkg::OP_DEC;
        if (st.start_go) begin
          state_nxt = st.run_old ? sstq_pkg::S_R_ADDR : sstq_pkg::S_I_ADDR;
        end else if (st.stop_go) begin
          state_nxt = st.run_old ? sstq_pkg::S_R_ADDR : sstq_pkg::S_T_ADDR;
        end else if (st.svc && !st.lvl_empty) begin
          state_nxt = sstq_pkg::S_SV_ADDR;
        end else begin
          state_nxt = sstq_pkg::S_T_ADDR;
        end
      end
      sstq_pkg::S_SV_ADDR: begin
        op        = sstq_pkg::OP_SV_ADDR;
        state_nxt = sstq_pkg::S_SV_FETCH;
      end
      sstq_pkg::S_SV_FETCH: begin
        op        = sstq_pkg::OP_SV_FETCH;
        state_nxt = sstq_pkg::S_SV_CHECK;
      end
      sstq_pkg::S_SV_CHECK: begin
        op        = sstq_pkg::OP_SV_CHECK;
        state_nxt = st.due ? sstq_pkg::S_R_ADDR : sstq_pkg::S_T_ADDR;
      end
      sstq_pkg::S_R_ADDR: begin
        if (st.scan_end) begin
          op        = sstq_pkg::OP_R_SKIP;
          state_nxt = st.ins_pend ? sstq_pkg::S_I_ADDR : sstq_pkg::S_T_ADDR;
        end else begin
          op        = sstq_pkg::OP_R_ADDR;
          state_nxt = sstq_pkg::S_R_CMP;
        end
      end
      sstq_pkg::S_R_CMP: begin
        op        = sstq_pkg::OP_R_CMP;
        state_nxt = st.match ? sstq_pkg::S_RS_ADDR : sstq_pkg::S_R_ADDR;
      end
      sstq_pkg::S_RS_ADDR: begin
        if (st.rs_end) begin
          op        = sstq_pkg::OP_R_DONE;
          state_nxt = st.ins_pend ? sstq_pkg::S_I_ADDR : sstq_pkg::S_T_ADDR;
        end else begin
          op        = sstq_pkg::OP_RS_ADDR;
          state_nxt = sstq_pkg::S_RS_WR;
        end
      end
      sstq_pkg::S_RS_WR: begin
        op        = sstq_pkg::OP_RS_WR;
        state_nxt = sstq_pkg::S_RS_ADDR;
      end
      sstq_pkg::S_I_ADDR: begin
        if (st.full) begin
          state_nxt = sstq_pkg::S_T_ADDR;
        end else if (st.scan_end) begin
          op        = sstq_pkg::OP_P_INIT;
          state_nxt = sstq_pkg::S_P;
        end else begin
          op        = sstq_pkg::OP_I_ADDR;
          state_nxt = sstq_pkg::S_I_FETCH;
        end
      end
      sstq_pkg::S_I_FETCH: begin
        op        = sstq_pkg::OP_I_FETCH;
        state_nxt = sstq_pkg::S_I_CMP;
      end
      sstq_pkg::S_I_CMP: begin
        op        = sstq_pkg::OP_I_CMP;
        state_nxt = st.later ? sstq_pkg::S_P : sstq_pkg::S_I_ADDR;
      end
      sstq_pkg::S_P: begin
        if (st.p_end) begin
          op        = sstq_pkg::OP_PLACE;
          state_nxt = sstq_pkg::S_T_ADDR;
        end else begin
          op        = sstq_pkg::OP_P_ADDR;
          state_nxt = sstq_pkg::S_P_WR;
        end
      end
      sstq_pkg::S_P_WR: begin
        op        = sstq_pkg::OP_P_WR;
        state_nxt = sstq_pkg::S_P;
      end
      sstq_pkg::S_T_ADDR: begin
        op        = sstq_pkg::OP_T_ADDR;
        state_nxt = sstq_pkg::S_T_FETCH;
      end
      sstq_pkg::S_T_FETCH: begin
        op        = sstq_pkg::OP_T_FETCH;
        state_nxt = sstq_pkg::S_T_CALC;
      end
      sstq_pkg::S_T_CALC: begin
        op        = sstq_pkg::OP_T_CALC;
        state_nxt = sstq_pkg::S_FIN;
      end
      sstq_pkg::S_FIN: begin
        if (st.out_free) begin
          op        = sstq_pkg::OP_OUT;
          state_nxt = sstq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sstq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/sstq_dp.sv */
`default_nettype none

module sstq_dp #(
  parameter int NUM_TIMERS    = sstq_pkg::NUM_TIMERS_DEF,
  parameter int NUM_LEVELS    = sstq_pkg::NUM_LEVELS_DEF,
  parameter int INTERVAL_BITS = sstq_pkg::INTERVAL_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  sstq_pkg::dp_op_t     op,
  output sstq_pkg::dp_status_t st,
  input  wire  [1:0]           in_func,
  input  wire  [3:0]           in_timer_id,
  input  wire  [31:0]          in_delay,
  input  wire                  in_absolute,
  input  wire                  in_repeat_req,
  input  wire  [26:0]          in_interval,
  input  wire                  in_high_level,
  input  wire  [31:0]          in_now,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic                 out_fired,
  output logic [3:0]           out_fired_id,
  output logic [31:0]          out_next_timeout
);

  localparam int IDW   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW    = $clog2(NUM_TIMERS + 1);
  localparam int LVW   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int IB    = INTERVAL_BITS;
  localparam int NLV   = 1 << LVW;
  localparam int ODEP  = 1 << (LVW + IDW);

  // Per-slot flags and list fill counts.
  logic [NUM_TIMERS-1:0] running_r;
  logic [NUM_TIMERS-1:0] periodic_r;
  logic [LVW-1:0]        slvl_r [NUM_TIMERS];
  logic [CW-1:0]         count_r [NLV];

  logic [IDW-1:0]        order_mem [ODEP];
  logic [31:0]           fire_mem  [NUM_TIMERS];
  logic [IB-1:0]         reload_mem [NUM_TIMERS];

  logic [1:0]     func_r;
  logic           id_ok_r;
  logic [IDW-1:0] slot_r;
  logic [LVW-1:0] lv_r;
  logic [31:0]    now_r;
  logic [31:0]    delay_r;
  logic           abs_r;
  logic           rep_r;
  logic [IB-1:0]  ival_r;

  logic [LVW-1:0] wl_r;
  logic [IDW-1:0] wid_r;
  logic [31:0]    f_r;
  logic [CW-1:0]  pos_r;
  logic [CW-1:0]  j_r;
  logic           ins_pend_r;
  logic           fired_r;
  logic [IDW-1:0] fid_r;
  logic [31:0]    tmo_r;
  logic [IDW-1:0] ord_q;
  logic [31:0]    fire_q;
  logic [IB-1:0]  rel_q;
  logic           out_valid_r;
  logic           out_fired_r;
  logic [3:0]     out_fid_r;
  logic [31:0]    out_tmo_r;

  logic [CW-1:0]  cnt;
  logic [CW-1:0]  jm1;
  logic [31:0]    d_now;
  logic [31:0]    d_key;
  logic [31:0]    start_tick;
  logic [IB-1:0]  reload_val;
  logic [31:0]    reloaded;
  logic           ord_re;
  logic [LVW+IDW-1:0] ord_raddr;
  logic           ord_we;
  logic [LVW+IDW-1:0] ord_waddr;
  logic [IDW-1:0] ord_wdata;

  assign cnt        = count_r[wl_r];
  assign jm1        = j_r - CW'(1);
  assign d_now      = fire_q - now_r;
  assign d_key      = fire_q - f_r;
  assign start_tick = abs_r ? delay_r : delay_r + now_r;
  assign reload_val = rep_r ? ((ival_r != '0) ? ival_r : delay_r[IB-1:0]) : '0;
  assign reloaded   = fire_q + 32'(rel_q);

  always_comb begin
    st.start_go  = (func_r == sstq_pkg::FUNC_START) && id_ok_r;
    st.stop_go   = (func_r == sstq_pkg::FUNC_STOP) && id_ok_r;
    st.svc       = (func_r == sstq_pkg::FUNC_SERVICE);
    st.run_old   = running_r[slot_r];
    st.lvl_empty = (count_r[lv_r] == '0);
    st.due       = (d_now == '0) || d_now[31];
    st.ins_pend  = ins_pend_r;
    st.scan_end  = (pos_r == cnt);
    st.match     = (ord_q == wid_r);
    st.rs_end    = (j_r == cnt);
    st.full      = (cnt == CW'(NUM_TIMERS));
    st.later     = (d_key != '0) && !d_key[31];
    st.p_end     = (j_r == pos_r);
    st.out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    ord_re    = 1'b1;
    ord_raddr = {wl_r, pos_r[IDW-1:0]};
    case (op)
      sstq_pkg::OP_SV_ADDR: ord_raddr = {wl_r, IDW'(0)};
      sstq_pkg::OP_R_ADDR,
      sstq_pkg::OP_I_ADDR:  ord_raddr = {wl_r, pos_r[IDW-1:0]};
      sstq_pkg::OP_RS_ADDR: ord_raddr = {wl_r, j_r[IDW-1:0]};
      sstq_pkg::OP_P_ADDR:  ord_raddr = {wl_r, jm1[IDW-1:0]};
      sstq_pkg::OP_T_ADDR:  ord_raddr = {lv_r, IDW'(0)};
      default:              ord_re    = 1'b0;
    endcase
  end

  always_comb begin
    ord_we    = 1'b1;
    ord_waddr = {wl_r, pos_r[IDW-1:0]};
    ord_wdata = ord_q;
    case (op)
      sstq_pkg::OP_RS_WR: ord_waddr = {wl_r, jm1[IDW-1:0]};
      sstq_pkg::OP_P_WR:  ord_waddr = {wl_r, j_r[IDW-1:0]};
      sstq_pkg::OP_PLACE: ord_wdata = wid_r;
      default:            ord_we    = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      order_mem[ord_waddr] <= ord_wdata;
    end
    if (ord_re) begin
      ord_q <= order_mem[ord_raddr];
    end
    if (op == sstq_pkg::OP_DEC && st.start_go) begin
      fire_mem[slot_r]   <= start_tick;
      reload_mem[slot_r] <= reload_val;
    end else if (op == sstq_pkg::OP_SV_CHECK && st.due && periodic_r[ord_q]) begin
      fire_mem[ord_q] <= reloaded;
    end
    if (op == sstq_pkg::OP_SV_FETCH || op == sstq_pkg::OP_I_FETCH ||
        op == sstq_pkg::OP_T_FETCH) begin
      fire_q <= fire_mem[ord_q];
    end
    if (op == sstq_pkg::OP_SV_FETCH) begin
      rel_q <= reload_mem[ord_q];
    end
  end

  // Working registers of the current operation.
  always_ff @(posedge clk) begin
    case (op)
      sstq_pkg::OP_LOAD: begin
        func_r  <= in_func;
        id_ok_r <= (32'(in_timer_id) < 32'(NUM_TIMERS));
        slot_r  <= IDW'(in_timer_id);
        lv_r    <= (32'(in_high_level) >= 32'(NUM_LEVELS)) ? LVW'(NUM_LEVELS - 1)
                                                           : LVW'(in_high_level);
        now_r   <= in_now;
        delay_r <= in_delay;
        abs_r   <= in_absolute;
        rep_r   <= in_repeat_req;
        ival_r  <= IB'(in_interval);
      end
      sstq_pkg::OP_DEC: begin
        fired_r    <= 1'b0;
        fid_r      <= '0;
        pos_r      <= '0;
        wid_r      <= slot_r;
        f_r        <= start_tick;
        ins_pend_r <= st.start_go;
        if ((st.start_go || st.stop_go) && st.run_old) begin
          wl_r <= slvl_r[slot_r];
        end else begin
          wl_r <= lv_r;
        end
      end
      sstq_pkg::OP_SV_CHECK: begin
        pos_r <= '0;
        if (st.due) begin
          wid_r      <= ord_q;
          fired_r    <= 1'b1;
          fid_r      <= ord_q;
          ins_pend_r <= periodic_r[ord_q];
          f_r        <= reloaded;
        end
      end
      sstq_pkg::OP_R_CMP: begin
        if (st.match) begin
          j_r <= pos_r + CW'(1);
        end else begin
          pos_r <= pos_r + CW'(1);
        end
      end
      sstq_pkg::OP_RS_WR: j_r <= j_r + CW'(1);
      sstq_pkg::OP_R_SKIP,
      sstq_pkg::OP_R_DONE: begin
        wl_r  <= lv_r;
        pos_r <= '0;
      end
      sstq_pkg::OP_I_CMP: begin
        if (st.later) begin
          j_r <= cnt;
        end else begin
          pos_r <= pos_r + CW'(1);
        end
      end
      sstq_pkg::OP_P_INIT: j_r <= cnt;
      sstq_pkg::OP_P_WR:   j_r <= jm1;
      sstq_pkg::OP_T_CALC: begin
        if (count_r[lv_r] == '0) begin
          tmo_r <= sstq_pkg::TIMEOUT_EMPTY;
        end else begin
          tmo_r <= st.due ? 32'd0 : d_now;
        end
      end
      sstq_pkg::OP_OUT: begin
        out_fired_r <= fired_r;
        out_fid_r   <= 4'(fid_r);
        out_tmo_r   <= tmo_r;
      end
      default: begin
      end
    endcase
    if (op == sstq_pkg::OP_DEC && st.start_go) begin
      periodic_r[slot_r] <= rep_r;
      slvl_r[slot_r]     <= lv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NLV; i++) begin
        count_r[i] <= '0;
      end
    end else begin
      if (op == sstq_pkg::OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (op == sstq_pkg::OP_DEC && st.start_go) begin
        running_r[slot_r] <= 1'b1;
      end else if (op == sstq_pkg::OP_DEC && st.stop_go) begin
        running_r[slot_r] <= 1'b0;
      end else if (op == sstq_pkg::OP_SV_CHECK && st.due && !periodic_r[ord_q]) begin
        running_r[ord_q] <= 1'b0;
      end
      if (op == sstq_pkg::OP_R_DONE) begin
        count_r[wl_r] <= cnt - CW'(1);
      end else if (op == sstq_pkg::OP_PLACE) begin
        count_r[wl_r] <= cnt + CW'(1);
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fired        = out_fired_r;
  assign out_fired_id     = out_fid_r;
  assign out_next_timeout = out_tmo_r;

endmodule

`default_nettype wire

/* rtl/core/sorted_software_timer_queue_unit.sv */
`default_nettype none

// Sorted timer queue: NUM_TIMERS slots held in NUM_LEVELS lists, each ordered
// by fire tick under wrapping signed comparison, ties kept in insertion order.
// Every input transfer (start, stop, service or an unused function code)
// yields exactly one result transfer that carries the fired flag, the fired
// slot and the ticks left until the head of the selected level is due. Items
// are handled one at a time by a sequencer that walks the ordered list memory
// one entry per step: a removal scan over the entries passed and a shift of
// the entries behind, an insertion scan over the entries passed and a shift
// of the entries moved, and fixed work around them; the result waits while
// the output register stays stalled.
// A new item is taken while the previous result still waits in the output
// register.
module sorted_software_timer_queue_unit #(
  parameter int NUM_TIMERS    = sstq_pkg::NUM_TIMERS_DEF,
  parameter int NUM_LEVELS    = sstq_pkg::NUM_LEVELS_DEF,
  parameter int INTERVAL_BITS = sstq_pkg::INTERVAL_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_func,
  input  wire  [3:0]  in_timer_id,
  input  wire  [31:0] in_delay,
  input  wire         in_absolute,
  input  wire         in_repeat_req,
  input  wire  [26:0] in_interval,
  input  wire         in_high_level,
  input  wire  [31:0] in_now,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_fired,
  output logic [3:0]  out_fired_id,
  output logic [31:0] out_next_timeout
);

  sstq_pkg::dp_op_t     op;
  sstq_pkg::dp_status_t st;

  sstq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .in_stall (in_stall),
    .op       (op)
  );

  sstq_dp #(
    .NUM_TIMERS    (NUM_TIMERS),
    .NUM_LEVELS    (NUM_LEVELS),
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .st               (st),
    .in_func          (in_func),
    .in_timer_id      (in_timer_id),
    .in_delay         (in_delay),
    .in_absolute      (in_absolute),
    .in_repeat_req    (in_repeat_req),
    .in_interval      (in_interval),
    .in_high_level    (in_high_level),
    .in_now           (in_now),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_fired        (out_fired),
    .out_fired_id     (out_fired_id),
    .out_next_timeout (out_next_timeout)
  );

endmodule

`default_nettype wire

/* dv/sorted_software_timer_queue_unit_test.sv */
`default_nettype none

module sorted_software_timer_queue_unit_test;

  localparam int NT = 16;
  localparam int NL = 2;
  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  timer_id;
    logic [31:0] delay;
    logic        absolute;
    logic        repeat_req;
    logic [26:0] interval;
    logic        high_level;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    logic        fired;
    logic [3:0]  fired_id;
    logic [31:0] next_timeout;
  } res_t;

  typedef struct {
    cmd_t cmd;
    logic typed;
    res_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cmd_t in_cmd = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_fired;
  logic [3:0] out_fired_id;
  logic [31:0] out_next_timeout;

  sorted_software_timer_queue_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_cmd.func), .in_timer_id(in_cmd.timer_id), .in_delay(in_cmd.delay),
    .in_absolute(in_cmd.absolute), .in_repeat_req(in_cmd.repeat_req),
    .in_interval(in_cmd.interval), .in_high_level(in_cmd.high_level),
    .in_now(in_cmd.now),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_fired(out_fired), .out_fired_id(out_fired_id),
    .out_next_timeout(out_next_timeout)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the timer queue state.
  logic [31:0] tick_of [NT];
  logic [26:0] reload_of [NT];
  logic        is_periodic [NT];
  logic        is_running [NT];
  logic        level_of [NT];
  logic [3:0]  order [NL][$];

  res_t expected_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int fires_seen = 0;
  int items_sent = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic logic is_due(logic [31:0] d);
    return (d == 0) || d[31];
  endfunction

  task automatic queue_remove(int lv, logic [3:0] id);
    for (int p = 0; p < order[lv].size(); p++)
      if (order[lv][p] == id) begin
        order[lv].delete(p);
        return;
      end
  endtask

  task automatic queue_insert(int lv, logic [3:0] id);
    int p;
    logic [31:0] d;
    p = 0;
    if (order[lv].size() >= NT) return;
    while (p < order[lv].size()) begin
      d = tick_of[order[lv][p]] - tick_of[id];
      if (d != 0 && !d[31]) break;
      p++;
    end
    order[lv].insert(p, id);
  endtask

  function automatic logic [31:0] ticks_left(int lv, logic [31:0] now);
    logic [31:0] d;
    if (order[lv].size() == 0) return sstq_pkg::TIMEOUT_EMPTY;
    d = tick_of[order[lv][0]] - now;
    return is_due(d) ? 32'd0 : d;
  endfunction

  task automatic predict_timer_op(cmd_t c, output res_t r);
    int lv;
    logic [3:0] id;
    lv = c.high_level;
    r = '0;
    case (c.func)
      sstq_pkg::FUNC_START: begin
        id = c.timer_id;
        if (is_running[id]) queue_remove(level_of[id], id);
        is_periodic[id] = c.repeat_req;
        reload_of[id] = !c.repeat_req ? 27'd0 :
                        (c.interval != 0 ? c.interval : c.delay[26:0]);
        tick_of[id] = c.absolute ? c.delay : c.delay + c.now;
        level_of[id] = c.high_level;
        is_running[id] = 1'b1;
        queue_insert(lv, id);
      end
      sstq_pkg::FUNC_STOP: begin
        id = c.timer_id;
        if (is_running[id]) queue_remove(level_of[id], id);
        is_running[id] = 1'b0;
      end
      sstq_pkg::FUNC_SERVICE: begin
        if (order[lv].size() != 0 && ticks_left(lv, c.now) == 0) begin
          id = order[lv].pop_front();
          if (is_periodic[id]) begin
            tick_of[id] = tick_of[id] + reload_of[id];
            queue_insert(lv, id);
          end else begin
            is_running[id] = 1'b0;
          end
          r.fired = 1'b1;
          r.fired_id = id;
        end
      end
      default: ;
    endcase
    r.next_timeout = ticks_left(lv, c.now);
  endtask

  // Valid stays high after the transfer; the next item or an idle cycle drops it.
  task automatic send_item(cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Predict at send time; the block handles items in order.
  task automatic run_item(cmd_t c, logic typed = 1'b0, res_t want = '0);
    res_t r;
    predict_timer_op(c, r);
    if (typed && r !== want && mismatches < 10)
      $display("table row disagrees with predictor: %h vs %h", want, r);
    expected_results.push_back(typed ? want : r);
    send_item(c);
  endtask

  always @(posedge clk) begin
    res_t got, want;
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      if (out_valid && !out_stall) begin
        got = '{out_fired, out_fired_id, out_next_timeout};
        results_seen++;
        if (out_fired) fires_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: fired %b/%b id %0d/%0d timeout %h/%h",
                       want.fired, got.fired, want.fired_id, got.fired_id,
                       want.next_timeout, got.next_timeout);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sorted_software_timer_queue_unit test failed");
      $finish;
    end
  end

  function automatic cmd_t mk(logic [1:0] f, logic [3:0] id, logic [31:0] dl,
                              logic ab, logic rp, logic [26:0] iv, logic hl,
                              logic [31:0] nw);
    cmd_t c;
    c = '{f, id, dl, ab, rp, iv, hl, nw};
    return c;
  endfunction

  // Mostly well-formed traffic around a drifting clock so that timers expire.
  function automatic cmd_t random_item(ref logic [31:0] clock_now);
    cmd_t c;
    int k;
    c.timer_id = 4'($urandom);
    c.absolute = 1'($urandom);
    c.repeat_req = 1'($urandom);
    c.high_level = 1'($urandom);
    c.interval = ($urandom_range(3) == 0) ? 27'($urandom) : 27'($urandom_range(40));
    if ($urandom_range(9) == 0) c.interval = '0;
    k = $urandom_range(99);
    clock_now = clock_now + $urandom_range(12);
    if ($urandom_range(49) == 0) clock_now = $urandom;
    c.now = clock_now;
    c.delay = ($urandom_range(7) == 0) ? $urandom : $urandom_range(60);
    if (c.absolute) c.delay = clock_now + c.delay - 20;
    if (k < 40) c.func = sstq_pkg::FUNC_START;
    else if (k < 52) c.func = sstq_pkg::FUNC_STOP;
    else if (k < 96) c.func = sstq_pkg::FUNC_SERVICE;
    else c.func = FUNC_NOP;
    return c;
  endfunction

  initial begin
    row_t rows[$];
    logic [31:0] clock_now;
    int phase_items;

    for (int i = 0; i < NT; i++) begin
      tick_of[i] = '0; reload_of[i] = '0; is_periodic[i] = 1'b0;
      is_running[i] = 1'b0; level_of[i] = 1'b0;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: empty lists, extremes, ties, wrap, zero reload, no-op.
    rows.push_back('{mk(sstq_pkg::FUNC_SERVICE, 0, 0, 0, 0, 0, 0, 0), 1,
                     '{0, 0, sstq_pkg::TIMEOUT_EMPTY}});
    rows.push_back('{mk(sstq_pkg::FUNC_SERVICE, 0, 0, 0, 0, 0, 1, '1), 1,
                     '{0, 0, sstq_pkg::TIMEOUT_EMPTY}});
    rows.push_back('{mk(sstq_pkg::FUNC_STOP, 4'd15, 0, 0, 0, 0, 1, 0), 1,
                     '{0, 0, sstq_pkg::TIMEOUT_EMPTY}});
    rows.push_back('{mk(FUNC_NOP, 4'd7, '1, 1, 1, '1, 1, '1), 1,
                     '{0, 0, sstq_pkg::TIMEOUT_EMPTY}});
    rows.push_back('{mk(sstq_pkg::FUNC_START, 4'd3, 32'd100, 0, 0, 0, 0, 32'd0), 1,
                     '{0, 0, 32'd100}});
    rows.push_back('{mk(sstq_pkg::FUNC_START, 4'd5, 32'd100, 1, 0, 0, 0, 32'd0), 1,
                     '{0, 0, 32'd100}});
    rows.push_back('{mk(sstq_pkg::FUNC_START, 4'd15, 32'd50, 0, 1, '1, 0, 32'd0), 0, '0});
    rows.push_back('{mk(sstq_pkg::FUNC_SERVICE, 0, 0, 0, 0, 0, 0, 32'd49), 1,
                     '{0, 0, 32'd1}});
    rows.push_back('{mk(sstq_pkg::FUNC_SERVICE, 0, 0, 0, 0, 0, 0, 32'd50), 1,
                     '{1, 4'd15, 32'd50}});
    rows.push_back('{mk(sstq_pkg::FUNC_SERVICE, 0, 0, 0, 0, 0, 0, 32'd100), 0, '0});
    rows.push_back('{mk(sstq_pkg::FUNC_SERVICE, 0, 0, 0, 0, 0, 0, 32'd100), 0, '0});
    rows.push_back('{mk(sstq_pkg::FUNC_STOP, 4'd15, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(sstq_pkg::FUNC_START, 4'd0, 32'hFFFF_FFF0, 0, 1, 0, 1, 32'h20),
                     0, '0});
    rows.push_back('{mk(sstq_pkg::FUNC_START, 4'd9, 32'd0, 1, 1, 0, 1, 32'd5), 0, '0});
    rows.push_back('{mk(sstq_pkg::FUNC_SERVICE, 0, 0, 0, 0, 0, 1, 32'd5), 0, '0});
    rows.push_back('{mk(sstq_pkg::FUNC_SERVICE, 0, 0, 0, 0, 0, 1, 32'd6), 0, '0});
    rows.push_back('{mk(sstq_pkg::FUNC_START, 4'd9, 32'h7FFF_FFFF, 0, 0, 0, 1, '1), 0, '0});
    rows.push_back('{mk(sstq_pkg::FUNC_START, 4'd3, 32'd10, 0, 1, 27'd1, 1, 32'd0), 0, '0});
    rows.push_back('{mk(sstq_pkg::FUNC_SERVICE, 0, 0, 0, 0, 0, 1, 32'h8000_0000), 0, '0});
    rows.push_back('{mk(sstq_pkg::FUNC_STOP, 4'd0, 0, 0, 0, 0, 1, 0), 0, '0});
    rows.push_back('{mk(sstq_pkg::FUNC_STOP, 4'd5, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(sstq_pkg::FUNC_STOP, 4'd3, 0, 0, 0, 0, 1, 0), 0, '0});
    rows.push_back('{mk(sstq_pkg::FUNC_STOP, 4'd9, 0, 0, 0, 0, 1, 0), 0, '0});
    foreach (rows[i]) run_item(rows[i].cmd, rows[i].typed, rows[i].res);

    // Random traffic in three idling phases, draining between them.
    clock_now = $urandom;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 66 : 0;
      recv_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 19 : 0;
      phase_items = (ph == 2) ? 226 : 200;
      for (int i = 0; i < phase_items; i++) begin
        run_item(random_item(clock_now));
        if (ph == 0 && i == 100) begin
          in_valid <= 1'b0;
          while (expected_results.size() != 0) @(posedge clk);
        end
      end
      in_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clk);
    end

    repeat (200) @(posedge clk);
    $display("Sent %0d timer commands; %0d results checked, %0d of them expiries.",
             items_sent, results_seen, fires_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("sorted_software_timer_queue_unit test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("sorted_software_timer_queue_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/sstq_pkg.sv
rtl/core/sstq_ctrl.sv
rtl/core/sstq_dp.sv
rtl/core/sorted_software_timer_queue_unit.sv
dv/sorted_software_timer_queue_unit_test.sv
